// ===== rtl/mgh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgh_pkg
// Types, constants and helper functions shared by the mass grid histogram.
// ----------------------------------------------------------------------------
package mgh_pkg;

  localparam int unsigned GRID_SIZE_DEF = 128;
  localparam int unsigned STORE_DEPTH   = 16384;
  localparam int unsigned ADDR_W        = 14;
  localparam int unsigned MASS_W        = 48;
  localparam int unsigned PMASS_W       = 32;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned QUO_W         = 16;
  localparam int unsigned FRAC_W        = 17;
  localparam int unsigned COLOR_W       = 8;
  localparam int unsigned GAIN_W        = 15;
  localparam int unsigned CNT_W         = 4;

  localparam logic [MASS_W-1:0]  MASS_MAX   = '1;
  localparam logic [FRAC_W-1:0]  FRAC_ONE   = 17'h10000;
  localparam logic [GAIN_W-1:0]  GAIN_RED   = 15'd25500;
  localparam logic [GAIN_W-1:0]  GAIN_GREEN = 15'd2550;
  localparam logic [GAIN_W-1:0]  GAIN_BLUE  = 15'd255;
  localparam logic [CNT_W-1:0]   DIV_LAST   = 4'd15;
  localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'hFF;

  typedef enum logic [1:0] {
    ACT_DEPOSIT = 2'd0,
    ACT_READ    = 2'd1,
    ACT_FRAME   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_DEP_WR,
    ST_RD_WAIT,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [PMASS_W-1:0]        particle_mass;
    logic [ADDR_W-1:0]         cell_index;
  } in_item_t;

  typedef struct packed {
    logic               dropped;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } out_item_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [MASS_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [FRAC_W-1:0] frac;
  } div_stat_t;

  function automatic logic [MASS_W-1:0] sat_add(input logic [MASS_W-1:0] a,
                                                input logic [PMASS_W-1:0] b);
    logic [MASS_W:0] sum;
    sum = {1'b0, a} + (MASS_W+1)'(b);
    return sum[MASS_W] ? MASS_MAX : sum[MASS_W-1:0];
  endfunction

  function automatic logic [COLOR_W-1:0] channel(input logic [FRAC_W-1:0] frac,
                                                 input logic [GAIN_W-1:0] gain);
    logic [32:0] prod;
    logic [16:0] v;
    prod = 33'(frac) * 33'(gain) + 33'd32768;
    v    = prod[32:16];
    return (v > 17'd255) ? COLOR_MAX : v[COLOR_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mgh_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgh_store
// Cell mass memory, one read and one write port, registered read data.
// Sweeps every entry to zero after reset.
// ----------------------------------------------------------------------------
module mgh_store
  import mgh_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mem_req_t          req_i,
  output logic [MASS_W-1:0]      rdata_o,
  output logic                   clr_busy_o
);

  logic [MASS_W-1:0] mem_q [STORE_DEPTH];
  logic [MASS_W-1:0] rdata_q;
  logic [ADDR_W:0]   clr_q, clr_d;
  logic              clr_busy;

  assign clr_busy = ~clr_q[ADDR_W];
  assign clr_d    = clr_busy ? clr_q + 1'b1 : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      mem_q[clr_q[ADDR_W-1:0]] <= '0;
    end else if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy;

endmodule
`default_nettype wire

// ===== rtl/mgh_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgh_map
// Two-stage coordinate to cell mapping: grid cells per axis, then the
// store index and the out-of-store check.
// ----------------------------------------------------------------------------
module mgh_map
  import mgh_pkg::*;
#(
  parameter int unsigned GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic signed [COORD_W-1:0] x_coord_i,
  input  wire logic signed [COORD_W-1:0] y_coord_i,
  output logic                           done_o,
  output logic [ADDR_W-1:0]              addr_o,
  output logic                           dropped_o
);

  localparam int unsigned CW = $clog2(GRID_SIZE);
  localparam int unsigned PW = COORD_W + CW + 1;
  localparam int unsigned IW = (2 * CW > ADDR_W) ? 2 * CW : ADDR_W + 1;
  localparam logic [CW:0] GRID_L = (CW+1)'(GRID_SIZE);

  logic [COORD_W-1:0] xb, yb;
  logic [PW-1:0]      xp, yp;
  logic [CW-1:0]      xc_d, yc_d, xc_q, yc_q;
  logic [IW-1:0]      idx_d, idx_q;
  logic               v1_q, v2_q;

  // offset binary, then scale by grid size and keep the integer part
  assign xb    = {~x_coord_i[COORD_W-1], x_coord_i[COORD_W-2:0]};
  assign yb    = {~y_coord_i[COORD_W-1], y_coord_i[COORD_W-2:0]};
  assign xp    = PW'(xb) * PW'(GRID_L);
  assign yp    = PW'(yb) * PW'(GRID_L);
  assign xc_d  = xp[COORD_W +: CW];
  assign yc_d  = yp[COORD_W +: CW];
  assign idx_d = IW'(xc_q) * IW'(GRID_L) + IW'(yc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xc_q <= xc_d;
      yc_q <= yc_d;
    end
    if (v1_q) begin
      idx_q <= idx_d;
    end
  end

  assign done_o    = v2_q;
  assign addr_o    = idx_q[ADDR_W-1:0];
  assign dropped_o = (idx_q >= IW'(STORE_DEPTH));

endmodule
`default_nettype wire

// ===== rtl/mgh_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mgh_div
// Radix-2 restoring divider for the normalized cell fraction
// cell * 2^16 / total, capped at 1.0, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mgh_div
  import mgh_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [MASS_W-1:0] num_i,
  input  wire logic [MASS_W-1:0] den_i,
  output div_stat_t              stat_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MASS_W-1:0] rem_q, rem_d;
  logic [MASS_W-1:0] den_q, den_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [MASS_W:0]   rem2;
  logic [MASS_W:0]   diff;
  logic              ge;

  assign rem2 = {rem_q, 1'b0};
  assign diff = rem2 - {1'b0, den_q};
  assign ge   = (rem2 >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    frac_d = frac_q;
    if (start_i) begin
      den_d = den_i;
      rem_d = num_i;
      quo_d = '0;
      cnt_d = '0;
      if (den_i == '0) begin
        frac_d = '0;
        done_d = 1'b1;
      end else if (num_i >= den_i) begin
        frac_d = FRAC_ONE;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[MASS_W-1:0] : rem2[MASS_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        frac_d = {1'b0, quo_q[QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    frac_q <= frac_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.frac = frac_q;

endmodule
`default_nettype wire

// ===== rtl/mass_grid_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mass_grid_histogram
// Nearest-grid-point mass deposition onto a square grid with per-cell
// RGB readout normalized by the frame's total mass.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i / in_stall_o / in_item_i) takes one item at a
//   time: deposit a particle, read and clear one cell, or start a frame.
//   out channel (out_valid_o / out_stall_i / out_item_o) returns exactly
//   one item for each input item, in order.
// Steps per item, accept to next accept:
//   new frame or unknown action: straight to the output
//   deposit: two map stages, memory read, memory write, output;
//   a particle outside the store skips the memory read and write
//   readout: memory read, cell clear, divider, output; the divider
//   works out all 16 quotient bits only when the total is not zero and the cell holds less than the total
// After reset all 16384 cell memory entries are swept to zero at one entry
// per cycle, with in_stall_o high. The total mass clears at once.
// The output register holds a result while out_stall_i is high; the next
// item is still taken and worked on, and it waits in its final state
// until the output register is free.
// ----------------------------------------------------------------------------
module mass_grid_histogram
  import mgh_pkg::*;
#(
  parameter int unsigned GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  ctrl_state_e        state_q, state_d;
  logic [MASS_W-1:0]  total_q, total_d;
  logic [PMASS_W-1:0] mass_q, mass_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  out_item_t          res_q, res_d;
  out_item_t          out_q;
  logic               out_valid_q, out_valid_d;
  logic               push;
  logic               accept;

  mem_req_t           mem_req;
  logic [MASS_W-1:0]  mem_rdata;
  logic               clr_busy;

  logic               map_start;
  logic               map_done;
  logic [ADDR_W-1:0]  map_addr;
  logic               map_dropped;

  logic               div_start;
  div_stat_t          div_stat;

  mgh_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rdata_o    (mem_rdata),
    .clr_busy_o (clr_busy)
  );

  mgh_map #(
    .GRID_SIZE (GRID_SIZE)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (map_start),
    .x_coord_i (in_item_i.x_coord),
    .y_coord_i (in_item_i.y_coord),
    .done_o    (map_done),
    .addr_o    (map_addr),
    .dropped_o (map_dropped)
  );

  mgh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mem_rdata),
    .den_i   (total_q),
    .stat_o  (div_stat)
  );

  assign in_stall_o = (state_q != ST_IDLE) || clr_busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    mass_d    = mass_q;
    addr_d    = addr_q;
    res_d     = res_q;
    push      = 1'b0;
    map_start = 1'b0;
    div_start = 1'b0;
    mem_req   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mass_d = in_item_i.particle_mass;
          res_d  = '0;
          case (in_item_i.action)
            ACT_DEPOSIT: begin
              map_start = 1'b1;
              state_d   = ST_MAP;
            end
            ACT_READ: begin
              mem_req.re   = 1'b1;
              mem_req.addr = in_item_i.cell_index;
              addr_d       = in_item_i.cell_index;
              state_d      = ST_RD_WAIT;
            end
            ACT_FRAME: begin
              total_d = '0;
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_MAP: begin
        if (map_done) begin
          addr_d = map_addr;
          if (map_dropped) begin
            total_d       = sat_add(total_q, mass_q);
            res_d.dropped = 1'b1;
            state_d       = ST_DONE;
          end else begin
            mem_req.re   = 1'b1;
            mem_req.addr = map_addr;
            state_d      = ST_DEP_WR;
          end
        end
      end
      ST_DEP_WR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = addr_q;
        mem_req.wdata = sat_add(mem_rdata, mass_q);
        total_d       = sat_add(total_q, mass_q);
        state_d       = ST_DONE;
      end
      ST_RD_WAIT: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = addr_q;
        mem_req.wdata = '0;
        div_start     = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_d.red   = channel(div_stat.frac, GAIN_RED);
          res_d.green = channel(div_stat.frac, GAIN_GREEN);
          res_d.blue  = channel(div_stat.frac, GAIN_BLUE);
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          push    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = push || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mass_q <= mass_d;
    addr_q <= addr_d;
    res_q  <= res_d;
    if (push) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a new output item only comes out of the final state
  a_push_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("output item not issued from final state");

  // channel gains are ordered, so the colors must be as well
  a_color_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.red >= out_item_o.green) &&
                    (out_item_o.green >= out_item_o.blue))
    else $error("color channels out of order");

  // a dropped particle carries no color
  a_dropped_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.dropped) |->
      (out_item_o.red == '0) && (out_item_o.green == '0) && (out_item_o.blue == '0))
    else $error("dropped item with color");

  // the divider only runs while a readout waits for it
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == ST_DIV))
    else $error("divider busy outside readout");

  // memory writes only in the two write states
  a_mem_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (state_q == ST_DEP_WR) || (state_q == ST_RD_WAIT))
    else $error("unexpected cell memory write");

endmodule
`default_nettype wire
